[rtl/core/dsrd_pkg.sv]
// Shared types and constants for the disk sector run-length decoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package dsrd_pkg;

  // Sector buffer size in bytes; bounds bytes_written before overflow
  localparam int unsigned SectorBytes = 256;
  // Bytes in one raw or fill record body
  localparam int unsigned RecordBytes = 256;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned TrackW = 6;
  localparam int unsigned RunW   = 9;
  localparam int unsigned StatW  = 3;
  // Written-byte counter holds 0..SectorBytes
  localparam int unsigned BwW    = $clog2(SectorBytes + 1);
  // Sum of the counter and a run length without wrap
  localparam int unsigned SumW   = ((BwW > RunW) ? BwW : RunW) + 1;

  // Header byte fields
  localparam int unsigned ModeRunBit  = 7;
  localparam int unsigned ModeFillBit = 6;

  typedef enum logic [StatW-1:0] {
    StData     = 3'd0,
    StDone     = 3'd1,
    StMismatch = 3'd2,
    StTrunc    = 3'd3,
    StOverflow = 3'd4
  } status_e;

  // One result word
  typedef struct packed {
    logic [ByteW-1:0] data_value;
    logic [RunW-1:0]  run_length;
    logic [ByteW-1:0] sector_number;
    status_e          status;
    logic             last;
  } result_t;

endpackage

`default_nettype wire

[rtl/core/dsrd_decoder.sv]
// Record parser: header/body state machine, run accounting, result forming.
// Depends on dsrd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dsrd_decoder (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [dsrd_pkg::TrackW-1:0] cfg_track_i,
  input  wire logic                        accept_i,
  input  wire logic [dsrd_pkg::ByteW-1:0]  in_byte_i,
  input  wire logic                        stream_end_i,
  output logic                             res_valid_o,
  output dsrd_pkg::result_t                res_o
);
  import dsrd_pkg::*;

  typedef enum logic [3:0] {
    PhTrack   = 4'd0,
    PhSecRaw  = 4'd1,
    PhSecFill = 4'd2,
    PhSecRun  = 4'd3,
    PhSecBad  = 4'd4,
    PhRaw     = 4'd5,
    PhFill    = 4'd6,
    PhLen     = 4'd7,
    PhEsc     = 4'd8,
    PhBody    = 4'd9,
    PhCount   = 4'd10,
    PhValue   = 4'd11
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [TrackW-1:0] track_q;
  logic [ByteW-1:0]  sector_q, sector_d;
  logic [RunW-1:0]   left_q, left_d;
  logic [ByteW-1:0]  esc_q, esc_d;
  logic [ByteW-1:0]  rcount_q, rcount_d;
  logic [BwW-1:0]    bw_q, bw_d;

  logic              run_emit;
  logic [ByteW-1:0]  run_value;
  logic [RunW-1:0]   run_count;
  logic              run_final;
  logic [RunW-1:0]   left_dec;
  logic [SumW-1:0]   bw_sum;

  // One-byte decrement of the remaining length, held at zero
  assign left_dec = (left_q != '0) ? (left_q - RunW'(1)) : '0;
  assign bw_sum   = SumW'(bw_q) + SumW'(run_count);

  // Parse one word and form its result
  always_comb begin
    phase_d     = phase_q;
    sector_d    = sector_q;
    left_d      = left_q;
    esc_d       = esc_q;
    rcount_d    = rcount_q;
    bw_d        = bw_q;
    run_emit    = 1'b0;
    run_value   = '0;
    run_count   = '0;
    run_final   = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '{data_value: '0, run_length: '0, sector_number: '0,
                    status: StData, last: 1'b0};

    if (accept_i) begin
      if (stream_end_i) begin
        // Truncated record: report and drop back to header search
        if (phase_q != PhTrack) begin
          res_valid_o   = 1'b1;
          res_o.status  = StTrunc;
          res_o.last    = 1'b1;
          if (phase_q == PhSecRaw || phase_q == PhSecFill ||
              phase_q == PhSecRun || phase_q == PhSecBad) begin
            res_o.sector_number = '0;
          end else begin
            res_o.sector_number = sector_q;
          end
          phase_d  = PhTrack;
          left_d   = '0;
          rcount_d = '0;
          bw_d     = '0;
        end
      end else begin
        unique case (phase_q)
          PhTrack: begin
            bw_d = '0;
            if (in_byte_i[TrackW-1:0] != track_q) begin
              phase_d = PhSecBad;
            end else if (in_byte_i[ModeRunBit]) begin
              phase_d = PhSecRun;
            end else if (in_byte_i[ModeFillBit]) begin
              phase_d = PhSecFill;
            end else begin
              phase_d = PhSecRaw;
            end
          end
          PhSecBad: begin
            sector_d            = in_byte_i;
            res_valid_o         = 1'b1;
            res_o.sector_number = in_byte_i;
            res_o.status        = StMismatch;
            res_o.last          = 1'b1;
            phase_d             = PhTrack;
            left_d              = '0;
            rcount_d            = '0;
            bw_d                = '0;
          end
          PhSecRaw: begin
            sector_d = in_byte_i;
            left_d   = RunW'(RecordBytes);
            phase_d  = PhRaw;
          end
          PhSecFill: begin
            sector_d = in_byte_i;
            phase_d  = PhFill;
          end
          PhSecRun: begin
            sector_d = in_byte_i;
            phase_d  = PhLen;
          end
          PhRaw: begin
            left_d    = left_dec;
            run_emit  = 1'b1;
            run_value = in_byte_i;
            run_count = RunW'(1);
            run_final = (left_dec == '0);
          end
          PhFill: begin
            run_emit  = 1'b1;
            run_value = in_byte_i;
            run_count = RunW'(RecordBytes);
            run_final = 1'b1;
          end
          PhLen: begin
            left_d  = RunW'(in_byte_i);
            phase_d = PhEsc;
          end
          PhEsc: begin
            esc_d = in_byte_i;
            if (left_q == '0) begin
              // Empty body ends the record at once
              run_emit  = 1'b1;
              run_final = 1'b1;
            end else begin
              phase_d = PhBody;
            end
          end
          PhBody: begin
            if (in_byte_i == esc_q) begin
              // Escape triple takes three bytes of length, or what is left
              left_d  = (left_q >= RunW'(3)) ? (left_q - RunW'(3)) : '0;
              phase_d = PhCount;
            end else begin
              left_d    = left_dec;
              run_emit  = 1'b1;
              run_value = in_byte_i;
              run_count = RunW'(1);
              run_final = (left_dec == '0);
            end
          end
          PhCount: begin
            rcount_d = in_byte_i;
            phase_d  = PhValue;
          end
          PhValue: begin
            phase_d   = PhBody;
            run_emit  = 1'b1;
            run_value = in_byte_i;
            run_count = RunW'(rcount_q);
            run_final = (left_q == '0);
          end
          default: begin
            phase_d  = PhTrack;
            left_d   = '0;
            rcount_d = '0;
            bw_d     = '0;
          end
        endcase

        // Account the run against the sector buffer
        if (run_emit) begin
          res_valid_o         = 1'b1;
          res_o.data_value    = run_value;
          res_o.run_length    = run_count;
          res_o.sector_number = sector_q;
          res_o.last          = run_final;
          if (bw_sum > SumW'(SectorBytes)) begin
            res_o.status = StOverflow;
            bw_d         = BwW'(SectorBytes);
          end else begin
            res_o.status = run_final ? StDone : StData;
            bw_d         = bw_sum[BwW-1:0];
          end
          if (run_final) begin
            phase_d  = PhTrack;
            left_d   = '0;
            rcount_d = '0;
            bw_d     = '0;
          end
        end
      end
    end
  end

  // Hold parser state and the track register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhTrack;
      track_q  <= '0;
      sector_q <= '0;
      left_q   <= '0;
      esc_q    <= '0;
      rcount_q <= '0;
      bw_q     <= '0;
    end else begin
      phase_q  <= phase_d;
      sector_q <= sector_d;
      left_q   <= left_d;
      esc_q    <= esc_d;
      rcount_q <= rcount_d;
      bw_q     <= bw_d;
      if (cfg_we_i) begin
        track_q <= cfg_track_i;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/dsrd_out_buffer.sv]
// Two-entry result buffer between the parser and the output channel.
// Depends on dsrd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dsrd_out_buffer (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire dsrd_pkg::result_t push_data_i,
  output logic                   full_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output dsrd_pkg::result_t      out_data_o
);
  import dsrd_pkg::*;

  result_t     mem_q [2];
  logic        wr_q, rd_q;
  logic [1:0]  count_q, count_d;
  logic        pop;

  assign out_valid_o = (count_q != 2'd0);
  assign full_o      = (count_q == 2'd2);
  assign pop         = out_valid_o && !out_stall_i;
  assign out_data_o  = mem_q[rd_q];

  // Track occupancy
  always_comb begin
    count_d = count_q;
    if (push_i && !pop) begin
      count_d = count_q + 2'd1;
    end else if (!push_i && pop) begin
      count_d = count_q - 2'd1;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
    end
  end

  // Store result words
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

[rtl/core/disk_sector_rle_decoder_top.sv]
// Disk sector run-length decoder, top level: parser plus output buffer.
// A result word is formed combinationally and registered in the output buffer.
// Throughput: one input word per cycle; the input stalls only while both
// result buffer entries are occupied.
// Reset (async, active low) returns to header search with expected track 0.
// Depends on dsrd_pkg, dsrd_decoder and dsrd_out_buffer.
`timescale 1ns / 1ps
`default_nettype none

module disk_sector_rle_decoder_top (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        expected_track_we_i,
  input  wire logic [dsrd_pkg::TrackW-1:0] expected_track_i,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [dsrd_pkg::ByteW-1:0]  in_byte_i,
  input  wire logic                        stream_end_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [dsrd_pkg::ByteW-1:0]       data_value_o,
  output logic [dsrd_pkg::RunW-1:0]        run_length_o,
  output logic [dsrd_pkg::ByteW-1:0]       sector_number_o,
  output logic [dsrd_pkg::StatW-1:0]       status_o,
  output logic                             last_o
);
  import dsrd_pkg::*;

  logic    buf_full;
  logic    accept;
  logic    res_valid;
  result_t res;
  result_t out_word;

  // Take a word whenever the buffer has room
  assign in_stall_o = buf_full;
  assign accept     = in_valid_i && !buf_full;

  dsrd_decoder u_decoder (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (expected_track_we_i),
    .cfg_track_i  (expected_track_i),
    .accept_i     (accept),
    .in_byte_i    (in_byte_i),
    .stream_end_i (stream_end_i),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  dsrd_out_buffer u_out_buffer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_word)
  );

  assign data_value_o    = out_word.data_value;
  assign run_length_o    = out_word.run_length;
  assign sector_number_o = out_word.sector_number;
  assign status_o        = out_word.status;
  assign last_o          = out_word.last;

endmodule

`default_nettype wire

[tb/sv/tb.sv]
// Self-checking testbench for disk_sector_rle_decoder_top: directed records, then random ones.
// Expected runs come from a cycle-free decoder written in this file; needs only dsrd_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
  import dsrd_pkg::*;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned RandomWords = 1000;
  localparam int unsigned PhaseCount  = 8;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned LongHold    = 300;
  localparam int unsigned MaxPrints   = 100;

  // Decoder parse phases
  typedef enum logic [3:0] {
    PhTrack, PhSecRaw, PhSecFill, PhSecRun, PhSecBad,
    PhRaw, PhFill, PhLen, PhEsc, PhBody, PhCount, PhValue
  } parse_phase_e;

  // How a directed row is checked
  typedef enum logic [1:0] {RowModel, RowQuiet, RowTyped, RowTrack} row_kind_e;

  typedef struct {
    row_kind_e  kind;
    logic [7:0] b;
    logic       eof;
    result_t    want;
  } stim_row_t;

  logic                clk_i               = 1'b0;
  logic                rst_ni              = 1'b0;
  logic                expected_track_we_i = 1'b0;
  logic [TrackW-1:0]   expected_track_i    = '0;
  logic                in_valid_i          = 1'b0;
  logic                in_stall_o;
  logic [ByteW-1:0]    in_byte_i           = '0;
  logic                stream_end_i        = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i         = 1'b0;
  logic [ByteW-1:0]    data_value_o;
  logic [RunW-1:0]     run_length_o;
  logic [ByteW-1:0]    sector_number_o;
  logic [StatW-1:0]    status_o;
  logic                last_o;

  disk_sector_rle_decoder_top uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .expected_track_we_i(expected_track_we_i),
    .expected_track_i   (expected_track_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .in_byte_i          (in_byte_i),
    .stream_end_i       (stream_end_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .data_value_o       (data_value_o),
    .run_length_o       (run_length_o),
    .sector_number_o    (sector_number_o),
    .status_o           (status_o),
    .last_o             (last_o)
  );

  always #1 clk_i = ~clk_i;

  // Decoder state, mirrored at reset values
  parse_phase_e parse_phase   = PhTrack;
  logic [5:0]   track_cfg     = '0;
  logic [7:0]   held_sector   = '0;
  logic [7:0]   esc_code      = '0;
  logic [7:0]   rep_count     = '0;
  logic [8:0]   len_left      = '0;
  int unsigned  bytes_written = 0;

  result_t      pending_runs[$];
  stim_row_t    directed_rows[$];
  logic [8:0]   record_words[$];
  int unsigned  err_count     = 0;
  int unsigned  cycle_count   = 0;
  bit           idle_on       = 1'b1;
  bit           hold_req      = 1'b0;

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= MaxPrints) $display("tb: mismatch at %0t: %s", $time, what);
  endtask

  function automatic void close_record();
    parse_phase   = PhTrack;
    len_left      = '0;
    rep_count     = '0;
    bytes_written = 0;
  endfunction

  // Account a run against the sector buffer; overflow marks the buffer full
  function automatic result_t sector_run(logic [7:0] value, int unsigned count, logic fin);
    result_t r;
    if (bytes_written + count > SectorBytes) begin
      r.status      = StOverflow;
      bytes_written = SectorBytes;
    end else begin
      bytes_written += count;
      r.status      = fin ? StDone : StData;
    end
    r.data_value    = value;
    r.run_length    = count[RunW-1:0];
    r.sector_number = held_sector;
    r.last          = fin;
    if (fin) close_record();
    return r;
  endfunction

  // Advance the decoder by one input word; return 1 when it yields a run
  function automatic bit decode_word(input logic [7:0] b, input logic eof, output result_t r);
    r = '0;
    if (eof) begin
      if (parse_phase == PhTrack) return 1'b0;
      r.sector_number = (parse_phase <= PhSecBad) ? 8'h00 : held_sector;
      r.status        = StTrunc;
      r.last          = 1'b1;
      close_record();
      return 1'b1;
    end
    case (parse_phase)
      PhTrack: begin
        bytes_written = 0;
        if (b[5:0] != track_cfg) parse_phase = PhSecBad;
        else if (b[ModeRunBit])  parse_phase = PhSecRun;
        else if (b[ModeFillBit]) parse_phase = PhSecFill;
        else                     parse_phase = PhSecRaw;
        return 1'b0;
      end
      PhSecBad: begin
        held_sector     = b;
        r.sector_number = b;
        r.status        = StMismatch;
        r.last          = 1'b1;
        close_record();
        return 1'b1;
      end
      PhSecRaw: begin
        held_sector = b;
        len_left    = 9'(RecordBytes);
        parse_phase = PhRaw;
        return 1'b0;
      end
      PhSecFill: begin
        held_sector = b;
        parse_phase = PhFill;
        return 1'b0;
      end
      PhSecRun: begin
        held_sector = b;
        parse_phase = PhLen;
        return 1'b0;
      end
      PhRaw: begin
        if (len_left != 0) len_left--;
        r = sector_run(b, 1, len_left == 0);
        return 1'b1;
      end
      PhFill: begin
        r = sector_run(b, RecordBytes, 1'b1);
        return 1'b1;
      end
      PhLen: begin
        len_left    = {1'b0, b};
        parse_phase = PhEsc;
        return 1'b0;
      end
      PhEsc: begin
        esc_code = b;
        if (len_left == 0) begin
          r = sector_run(8'h00, 0, 1'b1);
          return 1'b1;
        end
        parse_phase = PhBody;
        return 1'b0;
      end
      PhBody: begin
        // An escape starts a triple and takes three bytes of the length, or what is left
        if (b == esc_code) begin
          len_left    = (len_left >= 3) ? len_left - 9'd3 : 9'd0;
          parse_phase = PhCount;
          return 1'b0;
        end
        if (len_left != 0) len_left--;
        r = sector_run(b, 1, len_left == 0);
        return 1'b1;
      end
      PhCount: begin
        rep_count   = b;
        parse_phase = PhValue;
        return 1'b0;
      end
      PhValue: begin
        parse_phase = PhBody;
        r = sector_run(b, rep_count, len_left == 0);
        return 1'b1;
      end
      default: begin
        close_record();
        return 1'b0;
      end
    endcase
  endfunction

  function automatic void add_row(row_kind_e kind, logic [7:0] b, logic eof,
                                  logic [7:0] dv = '0, logic [8:0] rl = '0,
                                  logic [7:0] sec = '0, status_e st = StData,
                                  logic fin = 1'b0);
    stim_row_t row;
    row.kind               = kind;
    row.b                  = b;
    row.eof                = eof;
    row.want.data_value    = dv;
    row.want.run_length    = rl;
    row.want.sector_number = sec;
    row.want.status        = st;
    row.want.last          = fin;
    directed_rows.push_back(row);
  endfunction

  // Offer one word after a random gap while idle_on is set, hold it until taken, then predict
  task automatic feed(input logic [7:0] b, input logic eof, input bit use_model);
    int unsigned gap;
    result_t     got;
    bit          has_run;
    gap = idle_on ? $urandom_range(0, 19) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    in_byte_i    <= b;
    stream_end_i <= eof;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    has_run = decode_word(b, eof, got);
    if (has_run && use_model) pending_runs.push_back(got);
  endtask

  // Drain the block, let it settle, then write the track register
  task automatic set_track(input logic [5:0] trk);
    in_valid_i <= 1'b0;
    while (pending_runs.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    expected_track_we_i <= 1'b1;
    expected_track_i    <= trk;
    @(posedge clk_i);
    expected_track_we_i <= 1'b0;
    track_cfg = trk;
  endtask

  // Build one record for the current track: mostly well formed, some noise and cut-offs
  task automatic build_record();
    int unsigned pick, rem, cut, cnt;
    logic [7:0]  esc;
    record_words.delete();
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      repeat ($urandom_range(1, 6))
        record_words.push_back({($urandom_range(0, 7) == 0), 8'($urandom)});
      return;
    end
    if (pick < 18) begin
      record_words.push_back({1'b0, 2'($urandom), track_cfg ^ 6'($urandom_range(1, 63))});
      record_words.push_back({1'b0, 8'($urandom)});
    end else if (pick < 20) begin
      record_words.push_back({1'b0, 2'b00, track_cfg});
      record_words.push_back({1'b0, 8'($urandom)});
      repeat (RecordBytes) record_words.push_back({1'b0, 8'($urandom)});
    end else if (pick < 42) begin
      record_words.push_back({1'b0, 2'b01, track_cfg});
      record_words.push_back({1'b0, 8'($urandom)});
      record_words.push_back({1'b0, 8'($urandom)});
    end else begin
      record_words.push_back({1'b0, 1'b1, 1'($urandom), track_cfg});
      record_words.push_back({1'b0, 8'($urandom)});
      rem = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 24);
      esc = 8'($urandom);
      record_words.push_back({1'b0, rem[7:0]});
      record_words.push_back({1'b0, esc});
      while (rem != 0) begin
        if ($urandom_range(0, 2) == 0) begin
          case ($urandom_range(0, 2))
            0:       cnt = $urandom_range(0, 8);
            1:       cnt = $urandom_range(0, 255);
            default: cnt = $urandom_range(200, 255);
          endcase
          record_words.push_back({1'b0, esc});
          record_words.push_back({1'b0, cnt[7:0]});
          record_words.push_back({1'b0, 8'($urandom)});
          rem = (rem >= 3) ? rem - 3 : 0;
        end else begin
          record_words.push_back({1'b0, esc + 8'($urandom_range(1, 255))});
          rem--;
        end
      end
    end
    // Cut the record short now and then and end the stream there
    if ($urandom_range(0, 9) == 0) begin
      cut = $urandom_range(1, record_words.size());
      while (record_words.size() > cut) void'(record_words.pop_back());
      record_words.push_back({1'b1, 8'($urandom)});
    end
  endtask

  // Compare a taken result word with the oldest expected run
  task automatic check_run();
    result_t want;
    if (pending_runs.size() == 0) begin
      report_mismatch($sformatf("unexpected word value %0h length %0d status %0d",
                                data_value_o, run_length_o, status_o));
      return;
    end
    want = pending_runs.pop_front();
    if (data_value_o !== want.data_value)
      report_mismatch($sformatf("data_value %0h, want %0h", data_value_o, want.data_value));
    if (run_length_o !== want.run_length)
      report_mismatch($sformatf("run_length %0d, want %0d", run_length_o, want.run_length));
    if (sector_number_o !== want.sector_number)
      report_mismatch($sformatf("sector_number %0h, want %0h",
                                sector_number_o, want.sector_number));
    if (status_o !== want.status)
      report_mismatch($sformatf("status %0d, want %0d", status_o, want.status));
    if (last_o !== want.last)
      report_mismatch($sformatf("last %0b, want %0b", last_o, want.last));
  endtask

  // Receiver: random stall per word while idle_on is set, one long hold on request
  initial begin : result_sink
    int unsigned hold;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold     = LongHold;
        hold_req = 1'b0;
      end else begin
        hold = idle_on ? $urandom_range(0, 19) : 0;
      end
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!(out_valid_o === 1'b1 && out_stall_i === 1'b0));
      check_run();
    end
  end

  // Watchdog on total run time
  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb: errors");
    $finish;
  end

  initial begin : stimulus
    stim_row_t   row;
    int unsigned phase_words;

    // Reset track 0: idle end, truncated raw, fill, zero length
    add_row(RowQuiet, 8'h00, 1'b1);
    add_row(RowQuiet, 8'h00, 1'b0);
    add_row(RowQuiet, 8'hFF, 1'b0);
    add_row(RowTyped, 8'hA5, 1'b0, 8'hA5, 9'd1, 8'hFF, StData, 1'b0);
    add_row(RowTyped, 8'h5A, 1'b1, 8'h00, 9'd0, 8'hFF, StTrunc, 1'b1);
    add_row(RowQuiet, 8'h40, 1'b0);
    add_row(RowQuiet, 8'h00, 1'b0);
    add_row(RowTyped, 8'hFF, 1'b0, 8'hFF, 9'd256, 8'h00, StDone, 1'b1);
    add_row(RowQuiet, 8'h80, 1'b0);
    add_row(RowQuiet, 8'h12, 1'b0);
    add_row(RowQuiet, 8'h00, 1'b0);
    add_row(RowTyped, 8'h55, 1'b0, 8'h00, 9'd0, 8'h12, StDone, 1'b1);
    // Track 63: mismatch, then triples with zero count, short triple and overflow
    add_row(RowTrack, 8'h3F, 1'b0);
    add_row(RowQuiet, 8'h3E, 1'b0);
    add_row(RowTyped, 8'h7E, 1'b0, 8'h00, 9'd0, 8'h7E, StMismatch, 1'b1);
    add_row(RowQuiet, 8'hFF, 1'b0);
    add_row(RowQuiet, 8'h33, 1'b0);
    add_row(RowQuiet, 8'h07, 1'b0);
    add_row(RowQuiet, 8'h00, 1'b0);
    add_row(RowModel, 8'h00, 1'b0);
    add_row(RowModel, 8'hFF, 1'b0);
    add_row(RowModel, 8'h11, 1'b0);
    add_row(RowModel, 8'h00, 1'b0);
    add_row(RowModel, 8'h00, 1'b0);
    add_row(RowModel, 8'h80, 1'b0);
    add_row(RowModel, 8'h00, 1'b0);
    add_row(RowModel, 8'h02, 1'b0);
    add_row(RowModel, 8'h22, 1'b0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == RowTrack) begin
        set_track(row.b[5:0]);
      end else begin
        feed(row.b, row.eof, row.kind == RowModel);
        if (row.kind == RowTyped) pending_runs.push_back(row.want);
      end
    end

    // Random records over several tracks; three phases run back to back, one under a long hold
    for (int p = 0; p < PhaseCount; p++) begin
      set_track((p == 0) ? 6'd0 : (p == 1) ? 6'd63 : 6'($urandom_range(0, 63)));
      idle_on     = (p % 3) != 1;
      hold_req    = (p == 4);
      phase_words = 0;
      while (phase_words < RandomWords / PhaseCount) begin
        build_record();
        foreach (record_words[k]) feed(record_words[k][7:0], record_words[k][8], 1'b1);
        phase_words += record_words.size();
      end
    end

    in_valid_i <= 1'b0;
    while (pending_runs.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (err_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
